// ===== rtl/u2u_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u2u_pkg: shared types and constants of the UTF-8 to UCS-2 decoder
// Status codes, byte-class limits and the state/result records passed
// between the decode step and the top level.
// ----------------------------------------------------------------------------
package u2u_pkg;

    // End status codes
    localparam logic [1:0] ST_COMPLETE  = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_CAPACITY  = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    // Lead byte ranges and payload masks
    localparam logic [7:0] ASCII_MAX   = 8'h7F;
    localparam logic [7:0] LEAD2_MIN   = 8'hC0;
    localparam logic [7:0] LEAD2_MAX   = 8'hDF;
    localparam logic [7:0] LEAD3_MIN   = 8'hE0;
    localparam logic [7:0] LEAD3_MAX   = 8'hEF;
    localparam logic [7:0] LEAD2_MASK  = 8'h1F;
    localparam logic [7:0] LEAD3_MASK  = 8'h0F;
    localparam logic [7:0] CONT_MASK   = 8'h3F;

    localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

    // Per-string decoder state
    typedef struct packed {
        logic [15:0] partial_unit;
        logic [1:0]  bytes_pending;
        logic [15:0] unit_count;
        logic        halted;
        logic [1:0]  halt_cause;
    } t_state;

    // One result item plus its presence flag
    typedef struct packed {
        logic        present;
        logic [15:0] code_unit;
        logic        unit_valid;
        logic [15:0] units_so_far;
        logic        end_marker;
        logic [1:0]  end_status;
    } t_result;

endpackage : u2u_pkg
`default_nettype wire

// ===== rtl/u2u_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u2u_step: single-byte decode step
// Combinational update of the string state for one byte, producing the
// next state and at most one result item.
// ----------------------------------------------------------------------------
module u2u_step
    import u2u_pkg::*;
(
    input  var t_state      i_state,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_last_byte,
    input  wire logic [15:0] i_capacity,
    output var t_state      o_state,
    output var t_result     o_result
);

    t_state      s;
    logic        done;
    logic [15:0] unit;
    logic [15:0] cont_bits;
    logic [15:0] count_inc;
    logic [1:0]  status;

    always_comb begin
        s         = i_state;
        done      = 1'b0;
        unit      = 16'd0;
        cont_bits = {8'd0, i_in_byte & CONT_MASK};

        // Decode the byte unless stopped
        if (!i_state.halted) begin
            if (i_state.bytes_pending != 2'd0) begin
                // Fold in continuation bits: upper six when two remain, then lower six
                if (i_state.bytes_pending == 2'd2) begin
                    s.partial_unit = i_state.partial_unit | (cont_bits << 6);
                end else begin
                    s.partial_unit = i_state.partial_unit | cont_bits;
                end
                s.bytes_pending = i_state.bytes_pending - 2'd1;
                if (s.bytes_pending == 2'd0) begin
                    unit           = s.partial_unit;
                    done           = 1'b1;
                    s.partial_unit = 16'd0;
                end
            end else if (i_state.unit_count >= i_capacity) begin
                s.halted        = 1'b1;
                s.halt_cause    = ST_CAPACITY;
                s.bytes_pending = 2'd0;
                s.partial_unit  = 16'd0;
            end else begin
                case (i_in_byte) inside
                    [8'h00:ASCII_MAX]: begin
                        unit = {8'd0, i_in_byte};
                        done = 1'b1;
                    end
                    [LEAD2_MIN:LEAD2_MAX]: begin
                        s.partial_unit  = {3'd0, i_in_byte[4:0] & LEAD2_MASK[4:0], 8'd0} >> 2;
                        s.bytes_pending = 2'd1;
                    end
                    [LEAD3_MIN:LEAD3_MAX]: begin
                        s.partial_unit  = {i_in_byte[3:0] & LEAD3_MASK[3:0], 12'd0};
                        s.bytes_pending = 2'd2;
                    end
                    default: begin
                        s.halted        = 1'b1;
                        s.halt_cause    = ST_INVALID;
                        s.bytes_pending = 2'd0;
                        s.partial_unit  = 16'd0;
                    end
                endcase
            end
        end

        // Count the completed unit
        count_inc = s.unit_count + 16'd1;
        if (done) begin
            s.unit_count = count_inc;
        end

        // Pick the end status
        if (s.halted) begin
            status = s.halt_cause;
        end else if (s.bytes_pending != 2'd0) begin
            status = ST_TRUNCATED;
        end else begin
            status = ST_COMPLETE;
        end

        o_result.present      = done | i_last_byte;
        o_result.code_unit    = unit;
        o_result.unit_valid   = done;
        o_result.units_so_far = s.unit_count;
        o_result.end_marker   = i_last_byte;
        o_result.end_status   = i_last_byte ? status : ST_COMPLETE;

        // Clear the string state after the last byte
        if (i_last_byte) begin
            o_state = '0;
        end else begin
            o_state = s;
        end
    end

endmodule : u2u_step
`default_nettype wire

// ===== rtl/utf8_to_ucs2_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder: streaming UTF-8 to UCS-2 (BMP) decoder
// Assembles 16-bit code units from UTF-8 bytes and reports end of string.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall with i_in_byte and i_last_byte.
//   A byte is taken at a rising edge with i_in_valid high and o_in_stall low.
//   Output channel: o_out_valid / i_out_stall with the result fields.
//   A byte that completes a unit, or the byte marked last, gives one result
//   request; other bytes give none.
//   The result is written to the output register at the edge that takes the
//   byte. One byte per cycle while o_in_stall is low, set by the
//   combinational state update between the accept edge and the output register.
//   When the receiver stalls with a result pending, o_in_stall rises in the
//   same cycle and the result holds; it falls as soon as the result is taken.
//   i_cfg_we writes i_cfg_data as the output capacity; write it while idle.
//   Reset (i_rst_n low, synchronous) clears the string state, empties the
//   output register and sets the capacity to 65535.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder
    import u2u_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output var  logic        o_in_stall,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_last_byte,
    output var  logic        o_out_valid,
    input  wire logic        i_out_stall,
    output var  logic [15:0] o_code_unit,
    output var  logic        o_unit_valid,
    output var  logic [15:0] o_units_so_far,
    output var  logic        o_end_marker,
    output var  logic [1:0]  o_end_status
);

    logic [15:0] r_capacity;
    t_state      r_state;
    t_state      n_state;
    t_result     n_result;
    t_result     r_result;
    logic        r_out_valid;
    logic        in_accept;
    logic        out_take;

    // Hold input while an untaken result is stalled
    assign out_take   = r_out_valid & ~i_out_stall;
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;

    u2u_step u_step (
        .i_state     (r_state),
        .i_in_byte   (i_in_byte),
        .i_last_byte (i_last_byte),
        .i_capacity  (r_capacity),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_data;
        end
    end

    // Advance string state on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= n_result.present;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (in_accept && n_result.present) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_code_unit    = r_result.code_unit;
    assign o_unit_valid   = r_result.unit_valid;
    assign o_units_so_far = r_result.units_so_far;
    assign o_end_marker   = r_result.end_marker;
    assign o_end_status   = r_result.end_status;

`ifndef ASSERT_OFF
    // A stop leaves no sequence open
    a_halt_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.halted |-> (r_state.bytes_pending == 2'd0))
        else $error("halted with bytes pending");

    // A stop carries an invalid-lead or capacity cause
    a_halt_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.halted |-> (r_state.halt_cause == ST_INVALID ||
                            r_state.halt_cause == ST_CAPACITY))
        else $error("bad halt cause");

    // The last byte clears the string state
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_last_byte) |=> (r_state.unit_count == 16'd0 &&
                                        !r_state.halted &&
                                        r_state.bytes_pending == 2'd0))
        else $error("string state not cleared after last byte");

    // The last byte always yields an end result
    a_last_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_last_byte) |=> (o_out_valid && o_end_marker))
        else $error("missing end result");
`endif

endmodule : utf8_to_ucs2_decoder
`default_nettype wire
